// ===== rtl/core/srfc_pkg.sv =====
// types and constants shared by the sensor response frame checker
package srfc_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
  } out_item_t;

  typedef logic [2:0] byte_pos_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd2;
  localparam logic [1:0] STATUS_ALL_ONES  = 2'd3;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FUNC_CODE       = 8'h03;
  localparam logic [7:0]  BYTE_COUNT      = 8'h04;
  localparam logic [31:0] DATA_ALL_ONES   = 32'hFFFF_FFFF;

  localparam byte_pos_t POS_FUNC          = 3'd0;
  localparam byte_pos_t POS_COUNT         = 3'd1;
  localparam byte_pos_t POS_DATA0         = 3'd2;
  localparam byte_pos_t POS_DATA1         = 3'd3;
  localparam byte_pos_t POS_DATA2         = 3'd4;
  localparam byte_pos_t POS_DATA3         = 3'd5;
  localparam byte_pos_t POS_CRC_LO        = 3'd6;
  localparam byte_pos_t POS_CRC_HI        = 3'd7;

endpackage

// ===== rtl/core/srfc_crc_byte.sv =====
// one-byte update of the reflected crc-16, unrolled over eight bit steps
module srfc_crc_byte
  import srfc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ===== rtl/core/srfc_frame.sv =====
// frame tracking state, header and crc checks, and result decode
module srfc_frame
  import srfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  in_item,
  output logic      res_valid,
  output out_item_t res_item,
  output byte_pos_t byte_pos
);

  byte_pos_t   pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [31:0] data_r, data_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  byte_pos_t   pos_eff;
  logic [15:0] crc_eff;
  logic        hdr_ok_eff;
  logic [31:0] data_eff;
  logic [7:0]  crc_lo_eff;
  logic [15:0] crc_upd;
  logic [15:0] rx_crc;
  logic [15:0] mag;

  // a frame start drops any partial frame
  always_comb begin
    if (in_item.frame_start) begin
      pos_eff    = POS_FUNC;
      crc_eff    = CRC_INIT;
      hdr_ok_eff = 1'b1;
      data_eff   = '0;
      crc_lo_eff = '0;
    end else begin
      pos_eff    = pos_r;
      crc_eff    = crc_r;
      hdr_ok_eff = hdr_ok_r;
      data_eff   = data_r;
      crc_lo_eff = crc_lo_r;
    end
  end

  srfc_crc_byte u_crc (
    .crc_in  (crc_eff),
    .data_in (in_item.rx_byte),
    .crc_out (crc_upd)
  );

  assign rx_crc = {in_item.rx_byte, crc_lo_eff};
  assign mag    = {1'b0, data_eff[14:0]};

  always_comb begin
    pos_nxt    = pos_eff + 3'd1;
    crc_nxt    = crc_eff;
    hdr_ok_nxt = hdr_ok_eff;
    data_nxt   = data_eff;
    crc_lo_nxt = crc_lo_eff;
    res_valid  = 1'b0;
    res_item   = '0;
    case (pos_eff)
      POS_FUNC: begin
        hdr_ok_nxt = (in_item.rx_byte == FUNC_CODE);
        crc_nxt    = crc_upd;
      end
      POS_COUNT: begin
        hdr_ok_nxt = hdr_ok_eff && (in_item.rx_byte == BYTE_COUNT);
        crc_nxt    = crc_upd;
      end
      POS_DATA0, POS_DATA1, POS_DATA2, POS_DATA3: begin
        data_nxt = {data_eff[23:0], in_item.rx_byte};
        crc_nxt  = crc_upd;
      end
      POS_CRC_LO: begin
        crc_lo_nxt = in_item.rx_byte;
      end
      POS_CRC_HI: begin
        res_valid = 1'b1;
        if (!hdr_ok_eff) begin
          res_item.status = STATUS_BAD_HDR;
        end else if (rx_crc != crc_eff) begin
          res_item.status = STATUS_CRC_ERR;
        end else if (data_eff == DATA_ALL_ONES) begin
          res_item.status = STATUS_ALL_ONES;
        end else begin
          res_item.status          = STATUS_OK;
          res_item.humidity_tenths = data_eff[31:16];
          if (data_eff[15]) begin
            res_item.temperature_tenths = -mag;
          end else begin
            res_item.temperature_tenths = mag;
          end
        end
        pos_nxt    = POS_FUNC;
        crc_nxt    = CRC_INIT;
        hdr_ok_nxt = 1'b1;
        data_nxt   = '0;
        crc_lo_nxt = '0;
      end
      default: begin
        pos_nxt = POS_FUNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_FUNC;
      crc_r    <= CRC_INIT;
      hdr_ok_r <= 1'b1;
      data_r   <= '0;
      crc_lo_r <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      data_r   <= data_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  assign byte_pos = pos_r;

endmodule

// ===== rtl/core/sensor_response_frame_checker.sv =====
// top level of the sensor response frame checker
// Takes one response byte per cycle on the in_ channel (frame_start marks byte 0)
// and tracks an eight-byte frame: function code, byte count, four data bytes and
// a crc-16 sent low byte first. The crc update, header check and result decode
// are combinational logic on the frame state registers, so one item is accepted
// every cycle unless stalled; the result of the eighth byte is written to the
// output register when that byte is accepted. in_ready stays high while the output
// register is empty or being drained, so input stalls only when a result waits.
module sensor_response_frame_checker
  import srfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      accept;
  logic      res_valid;
  out_item_t res_item;
  byte_pos_t byte_pos;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  srfc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_item  (res_item),
    .byte_pos  (byte_pos)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_result_from_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.frame_start || byte_pos == POS_CRC_HI) && !in_item.frame_start)
      |=> out_valid)
    else $error("last byte of frame gave no result");

  a_failed_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STATUS_OK)
      |-> (out_item.humidity_tenths == 16'd0 && out_item.temperature_tenths == 16'sd0))
    else $error("failed frame carries nonzero readings");

  a_no_min_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.temperature_tenths != 16'sh8000))
    else $error("temperature out of sign-magnitude range");

  a_pos_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.frame_start) |=> (byte_pos == POS_COUNT))
    else $error("frame start did not restart byte count");
`endif

endmodule
